// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== sv/pacs_pkg.sv =====
// ----------------------------------------------------------------------------
// pacs_pkg
// Types and constants of the polyline arc/chord simplifier.
// ----------------------------------------------------------------------------
package pacs_pkg;

    localparam int CfgIdxW = 1;
    localparam logic [CfgIdxW-1:0] CFG_CHORD = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_SAG   = 1'b1;
    localparam logic [30:0] CHORD_RESET = 31'h7FFF_FFFF;
    localparam logic [30:0] SAG_RESET   = 31'h0001_0000;
    localparam logic [39:0] ARC_MAX     = 40'hFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic               segment_tag;
        logic               last_vertex;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] kept_x;
        logic signed [31:0] kept_y;
        logic signed [31:0] kept_z;
        logic               span_tag;
        logic               end_of_line;
    } t_out_item;

    // classified command from front to back
    typedef enum logic [1:0] {
        CMD_EMIT,      // emit vertex, new anchor
        CMD_SECOND,    // first step past anchor
        CMD_TEST,      // full arc/chord test
        CMD_LAST2      // last vertex right after anchor: emit only
    } t_cmd;

    typedef struct packed {
        t_cmd              cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic              tag;
        logic              last;
        logic              out_tag;
    } t_cmd_item;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_ACC, ST_ROOT, ST_S2, ST_S2H, ST_C2, ST_C2H, ST_DIFF,
        ST_DECIDE, ST_OUT1, ST_OUT2
    } t_state;

endpackage

// ===== sv/polyline_arc_chord_simplifier_top.sv =====
// ----------------------------------------------------------------------------
// polyline_arc_chord_simplifier_top
// Streaming greedy arc/chord polyline simplifier, Q16.16.
// ----------------------------------------------------------------------------
// Vertices enter on push/full (accepted when push && !full); kept
// vertices leave on empty/pop, oldest first. Configuration (chord and
// sag tolerances) is written on i_cfg_valid/o_cfg_ready, always ready.
// The front classifies each vertex into a two-entry command queue; the back
// runs the geometry on one digit-by-digit square root unit, a
// coordinate-difference squarer and a 40x20 multiplier that squares arc and
// chord in two halves each.
// Per vertex in the back: an anchor, tag-change or last-after-anchor vertex
// goes straight to output, the step after the anchor takes one root, a full
// test three (step, chord and sag), with difference squaring per distance,
// arc/chord squaring and their difference, plus start, decide and output.
// The back starts a command only when its two-entry result buffer is empty,
// so a stalled receiver stalls the back, then fills the queue and raises full.
// Reset empties all queues, zeroes the vertex count and loads the default
// tolerances.
// ----------------------------------------------------------------------------
module polyline_arc_chord_simplifier_top import pacs_pkg::*; #(
    parameter int DIMENSIONS = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_in,
    output logic        empty,
    input  logic        pop,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CfgIdxW-1:0] i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    logic [30:0] r_chord_tol, r_sag_tol;
    logic        w_q_full, w_q_push, w_q_empty, w_q_pop;
    t_cmd_item   w_cmd_in, w_cmd_out;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chord_tol <= CHORD_RESET;
            r_sag_tol   <= SAG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHORD: r_chord_tol <= i_cfg_data[30:0];
                CFG_SAG:   r_sag_tol   <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    pacs_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_item(i_in), .i_q_full(w_q_full),
        .o_full(full), .o_q_push(w_q_push), .o_cmd(w_cmd_in)
    );

    pacs_cmd_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(w_q_push), .i_data(w_cmd_in), .o_full(w_q_full),
        .i_pop(w_q_pop), .o_empty(w_q_empty), .o_data(w_cmd_out)
    );

    pacs_back #(.DIMENSIONS(DIMENSIONS)) u_back (
        .i_clk, .i_rst_n, .i_empty(w_q_empty), .i_cmd(w_cmd_out), .o_pop(w_q_pop),
        .i_chord_tol(r_chord_tol), .i_sag_tol(r_sag_tol),
        .o_empty(empty), .i_pop(pop), .o_item(o_out)
    );
endmodule

// ===== sv/pacs_front.sv =====
// ----------------------------------------------------------------------------
// pacs_front
// Accepts vertices, tracks tag and count, and classifies each into a command.
// ----------------------------------------------------------------------------
module pacs_front import pacs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_in_item  i_item,
    input  logic      i_q_full,
    output logic      o_full,
    output logic      o_q_push,
    output t_cmd_item o_cmd
);
    logic [1:0] r_count, n_count;
    logic       r_tag, n_tag;
    logic       w_acc;

    assign o_full   = i_q_full;
    assign w_acc    = i_push && !i_q_full;
    assign o_q_push = w_acc;

    // classify against the tracked count and tag
    always_comb begin
        n_count = r_count;
        n_tag   = r_tag;
        o_cmd.x = i_item.coord_x;
        o_cmd.y = i_item.coord_y;
        o_cmd.z = i_item.coord_z;
        o_cmd.tag = i_item.segment_tag;
        o_cmd.last = i_item.last_vertex;
        o_cmd.out_tag = i_item.segment_tag;
        o_cmd.cmd = CMD_TEST;
        if (r_count == 2'd0 || i_item.segment_tag != r_tag) begin
            o_cmd.cmd = CMD_EMIT;
            o_cmd.out_tag = (r_count == 2'd0) ? 1'b0 : r_tag;
            n_tag = i_item.segment_tag;
            n_count = i_item.last_vertex ? 2'd0 : 2'd1;
        end else if (r_count == 2'd1) begin
            o_cmd.cmd = i_item.last_vertex ? CMD_LAST2 : CMD_SECOND;
            n_count = i_item.last_vertex ? 2'd0 : 2'd2;
        end else begin
            n_count = i_item.last_vertex ? 2'd0 : 2'd3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
            r_tag   <= 1'b0;
        end else if (w_acc) begin
            r_count <= n_count;
            r_tag   <= n_tag;
        end
    end
endmodule

// ===== sv/pacs_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// pacs_cmd_fifo
// Two-entry command queue between front and back.
// ----------------------------------------------------------------------------
module pacs_cmd_fifo import pacs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_cmd_item i_data,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_empty,
    output t_cmd_item o_data
);
    t_cmd_item  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (i_push && !o_full) r_wp <= ~r_wp;
            if (i_pop && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_pop && !o_empty};
        end
    end
endmodule

// ===== sv/pacs_back.sv =====
// ----------------------------------------------------------------------------
// pacs_back
// Executes commands: distance squaring, shared digit-by-digit root, sag and chord test.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module pacs_back import pacs_pkg::*; #(
    parameter int DIMENSIONS = 3
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd_item i_cmd,
    output logic      o_pop,
    input  logic [30:0] i_chord_tol,
    input  logic [30:0] i_sag_tol,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_item
);
    t_state r_state, n_state;
    logic signed [31:0] r_ax, r_ay, r_az, r_px, r_py, r_pz;
    logic [39:0] r_arc;
    logic [39:0] r_step, r_chord;
    logic [1:0]  r_phase;   // 0 step, 1 chord, 2 sag
    logic [1:0]  r_dim;
    logic [64:0] r_sq;
    logic [66:0] r_sum;
    logic [79:0] r_s2;
    logic [79:0] r_rad;
    logic [41:0] r_rem;
    logic [39:0] r_root;
    logic [5:0]  r_bit;
    logic        r_bad_sag;
    t_out_item   r_out [2];
    logic        r_ob_wp, r_ob_rp;
    logic [1:0]  r_ob_cnt;
    t_out_item   w_put0, w_put1;
    logic        w_push0, w_push1;

    // output buffer: two entries, one command emits at most two items
    assign o_empty = (r_ob_cnt == 2'd0);
    assign o_item  = r_out[r_ob_rp];

    logic signed [32:0] w_d;
    logic signed [31:0] w_vc, w_rc;
    logic [43:0] w_rem_sh;
    logic [43:0] w_trial;
    logic        w_ge;
    logic [41:0] w_rem_nx;
    logic [39:0] w_root_nx;
    logic [40:0] w_arc_sum;
    logic [39:0] w_ma;
    logic [19:0] w_mb;
    logic [59:0] w_prod;

    // per-dimension operands
    always_comb begin
        logic signed [31:0] vz;
        vz = (DIMENSIONS >= 3) ? i_cmd.z : 32'sd0;
        unique case (r_dim)
            2'd0: w_vc = i_cmd.x;
            2'd1: w_vc = i_cmd.y;
            default: w_vc = vz;
        endcase
        priority case (r_dim)
            2'd0: w_rc = (r_phase == 2'd0) ? r_px : r_ax;
            2'd1: w_rc = (r_phase == 2'd0) ? r_py : r_ay;
            default: w_rc = (r_phase == 2'd0) ? r_pz : r_az;
        endcase
        w_d = 33'(w_vc) - 33'(w_rc);
    end

    // one restoring root step: two radicand bits per cycle, no multiplier
    assign w_rem_sh  = {r_rem, r_rad[79:78]};
    assign w_trial   = {2'b00, r_root, 2'b01};
    assign w_ge      = (w_rem_sh >= w_trial);
    assign w_rem_nx  = w_ge ? 42'(w_rem_sh - w_trial) : w_rem_sh[41:0];
    assign w_root_nx = {r_root[38:0], w_ge};
    assign w_arc_sum = {1'b0, r_arc} + {1'b0, w_root_nx};

    // arc and chord are squared in two halves on one 40x20 multiplier
    always_comb begin
        w_ma = (r_state == ST_S2 || r_state == ST_S2H) ? r_arc : r_chord;
        w_mb = (r_state == ST_S2 || r_state == ST_C2) ? w_ma[19:0] : w_ma[39:20];
    end
    assign w_prod = 60'(w_ma) * 60'(w_mb);

    always_comb begin
        n_state = r_state;
        o_pop = 1'b0;
        w_push0 = 1'b0; w_push1 = 1'b0;
        w_put0 = '0; w_put1 = '0;
        unique case (r_state)
            ST_IDLE: if (!i_empty && r_ob_cnt == 2'd0) begin
                unique case (i_cmd.cmd)
                    CMD_EMIT, CMD_LAST2: n_state = ST_OUT1;
                    default: n_state = ST_SQ;
                endcase
            end
            ST_SQ: n_state = ST_ACC;
            ST_ACC: n_state = (r_dim == 2'(DIMENSIONS - 1)) ? ST_ROOT : ST_SQ;
            ST_ROOT: if (r_bit == 6'd0) begin
                if (i_cmd.cmd == CMD_SECOND) n_state = ST_OUT1;
                else if (r_phase == 2'd0) n_state = ST_SQ;
                else if (r_phase == 2'd1) n_state = ST_S2;
                else n_state = ST_DECIDE;
            end
            ST_S2: n_state = ST_S2H;
            ST_S2H: n_state = ST_C2;
            ST_C2: n_state = ST_C2H;
            ST_C2H: n_state = ST_DIFF;
            ST_DIFF: n_state = ST_ROOT;
            ST_DECIDE: n_state = ST_OUT1;
            ST_OUT1: begin
                o_pop = 1'b1;
                n_state = ST_IDLE;
                w_put0.kept_x = i_cmd.x; w_put0.kept_y = i_cmd.y;
                w_put0.kept_z = (DIMENSIONS >= 3) ? i_cmd.z : 32'sd0;
                w_put0.span_tag = i_cmd.out_tag;
                w_put0.end_of_line = i_cmd.last;
                w_put1 = w_put0;
                unique case (i_cmd.cmd)
                    CMD_EMIT, CMD_LAST2: w_push0 = 1'b1;
                    CMD_SECOND: ;
                    default: begin
                        if (i_cmd.last) begin
                            if (r_bad_sag) begin
                                w_push0 = 1'b1;
                                w_put0.kept_x = r_px; w_put0.kept_y = r_py;
                                w_put0.kept_z = r_pz; w_put0.end_of_line = 1'b0;
                                w_push1 = 1'b1;
                            end else w_push0 = 1'b1;
                        end else if (r_bad_sag || !(r_chord < 40'(i_chord_tol))) begin
                            w_push0 = 1'b1;
                            w_put0.kept_x = r_px; w_put0.kept_y = r_py;
                            w_put0.kept_z = r_pz;
                        end
                    end
                endcase
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ob_wp <= 1'b0; r_ob_rp <= 1'b0; r_ob_cnt <= 2'd0;
            r_ax <= '0; r_ay <= '0; r_az <= '0;
            r_px <= '0; r_py <= '0; r_pz <= '0;
            r_arc <= '0;
        end else begin
            r_state <= n_state;
            r_ob_cnt <= r_ob_cnt + {1'b0, w_push0} + {1'b0, w_push1}
                        - {1'b0, i_pop && !o_empty};
            if (i_pop && !o_empty) r_ob_rp <= ~r_ob_rp;
            if (w_push0 && w_push1) r_ob_wp <= r_ob_wp;
            else if (w_push0) r_ob_wp <= ~r_ob_wp;
            unique case (r_state)
                ST_IDLE: begin
                    r_dim <= 2'd0; r_phase <= 2'd0; r_sum <= '0; r_bad_sag <= 1'b0;
                    r_root <= '0; r_rem <= '0; r_bit <= 6'd39;
                    if (!i_empty && i_cmd.cmd == CMD_SECOND) r_phase <= 2'd1;
                end
                ST_SQ: begin
                    r_sq  <= 65'((w_d[32] ? (-w_d) : w_d)) * 65'((w_d[32] ? (-w_d) : w_d));
                end
                ST_ACC: begin
                    r_sum <= r_sum + 67'(r_sq);
                    r_dim <= r_dim + 2'd1;
                    if (r_dim == 2'(DIMENSIONS - 1)) begin
                        r_rad <= 80'(r_sum + 67'(r_sq));
                        r_root <= '0; r_rem <= '0; r_bit <= 6'd39;
                    end
                end
                ST_ROOT: begin
                    r_rem  <= w_rem_nx;
                    r_root <= w_root_nx;
                    r_rad  <= r_rad << 2;
                    if (r_bit != 6'd0) r_bit <= r_bit - 6'd1;
                    else begin
                        r_dim <= 2'd0; r_sum <= '0;
                        unique case (r_phase)
                            2'd0: r_step <= w_root_nx;
                            2'd1: r_chord <= w_root_nx;
                            default: r_bad_sag <= !((w_root_nx >> 1) < 40'(i_sag_tol));
                        endcase
                        r_phase <= r_phase + 2'd1;
                        if (r_phase == 2'd0)
                            r_arc <= w_arc_sum[40] ? ARC_MAX : w_arc_sum[39:0];
                    end
                end
                ST_S2: r_s2 <= {20'd0, w_prod};
                ST_S2H: r_s2 <= r_s2 + {w_prod, 20'd0};
                ST_C2: r_rad <= {20'd0, w_prod};
                ST_C2H: r_rad <= r_rad + {w_prod, 20'd0};
                ST_DIFF: begin
                    // clamp a negative S^2 - C^2 to zero
                    r_rad <= (r_rad <= r_s2) ? r_s2 - r_rad : 80'd0;
                    r_root <= '0; r_rem <= '0; r_bit <= 6'd39;
                end
                ST_OUT1: begin
                    unique case (i_cmd.cmd)
                        CMD_EMIT: begin
                            r_ax <= i_cmd.x; r_ay <= i_cmd.y;
                            r_az <= (DIMENSIONS >= 3) ? i_cmd.z : 32'sd0;
                            r_px <= i_cmd.x; r_py <= i_cmd.y;
                            r_pz <= (DIMENSIONS >= 3) ? i_cmd.z : 32'sd0;
                            r_arc <= '0;
                        end
                        CMD_LAST2: ;
                        CMD_SECOND: begin
                            r_arc <= r_chord;
                            r_px <= i_cmd.x; r_py <= i_cmd.y;
                            r_pz <= (DIMENSIONS >= 3) ? i_cmd.z : 32'sd0;
                        end
                        default: if (!i_cmd.last) begin
                            if (r_bad_sag || !(r_chord < 40'(i_chord_tol))) begin
                                r_ax <= r_px; r_ay <= r_py; r_az <= r_pz;
                                r_arc <= r_step;
                            end
                            r_px <= i_cmd.x; r_py <= i_cmd.y;
                            r_pz <= (DIMENSIONS >= 3) ? i_cmd.z : 32'sd0;
                        end
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push0) r_out[r_ob_wp] <= w_put0;
        if (w_push1) r_out[~r_ob_wp] <= w_put1;
    end

    `ASSERT_CLK(a_ob_bound, i_clk, i_rst_n, r_ob_cnt <= 2'd2, "output buffer overflow")
    `ASSERT_CLK(a_pop_out1, i_clk, i_rst_n, o_pop |-> (r_state == ST_OUT1 && !i_empty),
                "command popped outside output state")
    `ASSERT_CLK(a_start_empty, i_clk, i_rst_n,
                (r_state == ST_IDLE && n_state != ST_IDLE) |-> (r_ob_cnt == 2'd0),
                "command started with results pending")
endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the polyline arc/chord simplifier.
// ----------------------------------------------------------------------------
// Feeds directed polylines and ones of random length and geometry through
// the push/full side, predicts every kept vertex with a bit-accurate
// software model of the greedy arc/chord rule and checks each popped item
// against it in order. Tolerances are rewritten between phases while idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import pacs_pkg::*;

// Keeps the tolerances and the run state, predicts kept vertices and checks
// popped items against them.
class kept_vertex_board;
    logic [30:0]        chord_tol;
    logic [30:0]        sag_tol;
    logic signed [31:0] anchor_pt[3];
    logic signed [31:0] prev_pt[3];
    logic               prev_tag;
    logic [39:0]        arc_len;
    int unsigned        vtx_count;
    t_out_item          kept_q[$];
    int                 n_err;
    int                 n_checked;

    function new();
        chord_tol = CHORD_RESET;
        sag_tol   = SAG_RESET;
        for (int k = 0; k < 3; k++) begin
            anchor_pt[k] = '0;
            prev_pt[k]   = '0;
        end
        prev_tag  = 1'b0;
        arc_len   = '0;
        vtx_count = 0;
        n_err     = 0;
        n_checked = 0;
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] span(logic signed [31:0] a[3], logic signed [31:0] b[3]);
        logic [127:0]       sum;
        logic signed [33:0] d;
        logic [33:0]        m;
        sum = '0;
        for (int k = 0; k < 3; k++) begin
            d = 34'(a[k]) - 34'(b[k]);
            m = d < 0 ? 34'(-d) : 34'(d);
            sum += {94'd0, m} * {94'd0, m};
        end
        return isqrt(sum);
    endfunction

    function automatic void emit(logic signed [31:0] p[3], logic tag, logic eol);
        t_out_item o;
        o.kept_x = p[0];
        o.kept_y = p[1];
        o.kept_z = p[2];
        o.span_tag = tag;
        o.end_of_line = eol;
        kept_q.insert(kept_q.size(), o);
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] data);
        if (idx == CFG_CHORD) chord_tol = data[30:0];
        else if (idx == CFG_SAG) sag_tol = data[30:0];
    endfunction

    // Note an accepted vertex and queue what it keeps.
    function void note_vertex(t_in_item it);
        logic signed [31:0] v[3];
        logic [63:0]  step;
        logic [63:0]  chord;
        logic [63:0]  sag;
        logic [64:0]  arc_sum;
        logic [127:0] s2;
        logic [127:0] c2;
        logic         sag_ok;
        logic         chord_ok;
        v[0] = it.coord_x;
        v[1] = it.coord_y;
        v[2] = it.coord_z;
        if (vtx_count == 0 || it.segment_tag != prev_tag) begin
            emit(v, vtx_count == 0 ? 1'b0 : prev_tag, it.last_vertex);
            anchor_pt = v;
            prev_pt   = v;
            prev_tag  = it.segment_tag;
            arc_len   = '0;
            vtx_count = it.last_vertex ? 0 : 1;
            return;
        end
        if (vtx_count == 1) begin
            if (it.last_vertex) begin
                emit(v, it.segment_tag, 1'b1);
                vtx_count = 0;
                return;
            end
            arc_len   = 40'(span(v, anchor_pt));
            prev_pt   = v;
            vtx_count = 2;
            return;
        end
        step    = span(v, prev_pt);
        arc_sum = {25'd0, arc_len} + {1'b0, step};
        arc_len = arc_sum > {25'd0, ARC_MAX} ? ARC_MAX : arc_sum[39:0];
        chord   = span(v, anchor_pt);
        s2 = {88'd0, arc_len} * {88'd0, arc_len};
        c2 = {64'd0, chord} * {64'd0, chord};
        sag = isqrt(c2 <= s2 ? s2 - c2 : '0) >> 1;
        sag_ok   = sag < {33'd0, sag_tol};
        chord_ok = chord < {33'd0, chord_tol};
        if (it.last_vertex) begin
            if (!sag_ok) emit(prev_pt, it.segment_tag, 1'b0);
            emit(v, it.segment_tag, 1'b1);
            vtx_count = 0;
            return;
        end
        if (sag_ok && chord_ok) begin
            prev_pt   = v;
            vtx_count = 3;
            return;
        end
        emit(prev_pt, it.segment_tag, 1'b0);
        anchor_pt = prev_pt;
        prev_pt   = v;
        arc_len   = 40'(step);
        vtx_count = 2;
    endfunction

    // Compare a popped item with the oldest kept vertex.
    function void check_kept(t_out_item got);
        t_out_item exp_o;
        n_checked++;
        if (kept_q.size() == 0) begin
            n_err++;
            if (n_err <= 10) $display("ERROR: unexpected item %h", got);
            return;
        end
        exp_o = kept_q.pop_front();
        if (got !== exp_o) begin
            n_err++;
            if (n_err <= 10) begin
                $display("ERROR: item %0d exp x=%h y=%h z=%h tag=%b eol=%b",
                         n_checked, exp_o.kept_x, exp_o.kept_y, exp_o.kept_z,
                         exp_o.span_tag, exp_o.end_of_line);
                $display("       got x=%h y=%h z=%h tag=%b eol=%b",
                         got.kept_x, got.kept_y, got.kept_z, got.span_tag,
                         got.end_of_line);
            end
        end
    endfunction
endclass

module tb_top;
    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_in;
    logic        empty;
    logic        pop;
    t_out_item   o_out;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [CfgIdxW-1:0] i_cfg_index;
    logic [31:0] i_cfg_data;

    kept_vertex_board board;
    int          push_idle_pct;
    int          pop_idle_pct;
    int          n_vertices;
    int          n_lines;

    polyline_arc_chord_simplifier_top #(.DIMENSIONS(3)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: random pop stalls, check at the rising edge.
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) board.check_kept(o_out);
    end

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // push stays high into the next item when the sender does not idle
    task automatic push_vertex(t_in_item it);
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push <= 1'b1;
        i_in <= it;
        do @(posedge i_clk); while (full);
        board.note_vertex(it);
        n_vertices++;
        if (it.last_vertex) n_lines++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (board.kept_q.size() != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
    endtask

    function automatic logic signed [31:0] near(logic signed [31:0] base);
        case ($urandom_range(3))
            0: return base + $signed(32'($urandom_range(131072))) - 32'sd65536;
            1: return base + $signed(32'($urandom_range(1 << 22))) - 32'sd2097152;
            2: return base;
            default: return $urandom;
        endcase
    endfunction

    // One polyline of random shape; mostly smooth walks, some noise.
    task automatic random_line(int len);
        t_in_item it;
        logic     tag;
        logic signed [31:0] p[3];
        tag = $urandom_range(1);
        for (int k = 0; k < 3; k++)
            p[k] = $urandom_range(1) ? $urandom : 32'($urandom_range(1 << 20));
        for (int i = 0; i < len; i++) begin
            for (int k = 0; k < 3; k++) p[k] = near(p[k]);
            if ($urandom_range(9) == 0) tag = ~tag;
            it.coord_x = p[0];
            it.coord_y = p[1];
            it.coord_z = p[2];
            it.segment_tag = tag;
            it.last_vertex = (i == len - 1);
            push_vertex(it);
        end
    endtask

    task automatic directed_line(logic signed [31:0] a, logic signed [31:0] b, int len,
                                 logic tagflip);
        t_in_item it;
        for (int i = 0; i < len; i++) begin
            it.coord_x = (i % 2) ? a : b;
            it.coord_y = (i % 2) ? b : a;
            it.coord_z = 32'(i) <<< 16;
            it.segment_tag = tagflip && (i == len - 1);
            it.last_vertex = (i == len - 1);
            push_vertex(it);
        end
    endtask

    initial begin
        board = new();
        i_rst_n = 1'b0;
        push = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_CHORD;
        i_cfg_data = '0;
        push_idle_pct = 0;
        pop_idle_pct = 0;
        n_vertices = 0;
        n_lines = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: single vertex, two vertices, extremes, tag change on last.
        directed_line(32'sh8000_0000, 32'sh7FFF_FFFF, 1, 1'b0);
        directed_line(32'sh8000_0000, 32'sh7FFF_FFFF, 2, 1'b0);
        directed_line(32'sh8000_0000, 32'sh7FFF_FFFF, 5, 1'b0);
        directed_line(32'sh0, 32'sh0001_0000, 4, 1'b1);
        directed_line(32'sh0, 32'sh0, 4, 1'b0);
        directed_line(32'sh7FFF_FFFF, 32'sh8000_0000, 3, 1'b1);
        drain();
        cfg_write(CFG_CHORD, 32'h0);
        cfg_write(CFG_SAG, 32'h0);
        directed_line(32'sh1234_5678, 32'shEDCB_A987, 5, 1'b0);
        drain();
        cfg_write(CFG_CHORD, 32'hFFFF_FFFF);
        cfg_write(CFG_SAG, 32'h7FFF_FFFF);
        directed_line(32'sh8000_0000, 32'sh7FFF_FFFF, 4, 1'b0);
        drain();

        // Random phases with varied idling and tolerances.
        for (int ph = 0; ph < 6; ph++) begin
            push_idle_pct = (ph < 2) ? 13 : (ph < 4) ? 87 : 0;
            pop_idle_pct  = (ph < 2) ? 87 : (ph < 4) ? 13 : 0;
            cfg_write(CFG_CHORD, (ph % 3 == 0) ? 32'h7FFF_FFFF : 32'($urandom_range(1 << 24)));
            cfg_write(CFG_SAG, (ph % 3 == 1) ? 32'h0 : 32'($urandom_range(1 << 20)));
            for (int l = 0; l < 11; l++) random_line($urandom_range(1, 12));
            // hold-off until every kept vertex is out
            drain();
        end

        $display("Summary: %0d vertices in %0d polylines, %0d kept items checked",
                 n_vertices, n_lines, board.n_checked);
        if (board.n_err == 0 && board.kept_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
